// File: design/bpa_pkg.sv
// Package for the buddy page allocator: node codes, command and status codes, defaults.
package bpa_pkg;

    localparam int MAX_ORDER_DEF  = 10;
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int ORDER_W        = 4;
    localparam int SIZE_W         = 32;
    localparam int OFFS_W         = 32;
    localparam int BLK_W          = 22;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd10;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    typedef enum logic [1:0] {
        NS_FREE = 2'd0,
        NS_PART = 2'd1,
        NS_USED = 2'd2
    } t_node;

endpackage

// File: design/bpa_req_if.sv
// Request channel: command, allocation size and offset to free.
interface bpa_req_if
    import bpa_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              command;
    logic [SIZE_W-1:0] size_bytes;
    logic [OFFS_W-1:0] free_offset;

    modport source (output valid, command, size_bytes, free_offset, input ready);
    modport sink   (input valid, command, size_bytes, free_offset, output ready);
endinterface

// File: design/bpa_rsp_if.sv
// Response channel: status and allocated block offset.
interface bpa_rsp_if
    import bpa_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             status;
    logic [BLK_W-1:0] block_offset;

    modport source (output valid, status, block_offset, input ready);
    modport sink   (input valid, status, block_offset, output ready);
endinterface

// File: design/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2047
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/bpa_ctrl.sv
// Sequencer for the buddy allocator: tree clear, search walk, free walk and ancestor repair.
module bpa_ctrl
    import bpa_pkg::*;
#(
    parameter int MAX_ORDER  = MAX_ORDER_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    localparam int AW = MAX_ORDER + 1,
    localparam int DW = $clog2(MAX_ORDER + 2)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic [DW-1:0] i_order,
    bpa_req_if.sink       i_req,
    bpa_rsp_if.source     o_rsp,
    output logic          o_mem_we,
    output logic [AW-1:0] o_mem_waddr,
    output logic [1:0]    o_mem_wdata,
    output logic [AW-1:0] o_mem_raddr,
    input  logic [1:0]    i_mem_rdata
);
    localparam int PS    = $clog2(PAGE_BYTES);
    localparam int NODES = (1 << AW) - 1;
    localparam int CW    = (PS + MAX_ORDER + 1 > 33) ? PS + MAX_ORDER + 1 : 33;
    localparam int OW    = (AW + PS > BLK_W) ? AW + PS : BLK_W;
    localparam int IW    = 5;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ROUND, S_SK_RD, S_SK_EV, S_SK_UP, S_FR_RD, S_FR_EV,
        S_FR_CH, S_MARK, S_UP_RD, S_UP_EV, S_DONE
    } t_state;

    t_state            r_state;
    logic [AW-1:0]     r_clr;
    logic [AW-1:0]     r_i;
    logic [DW-1:0]     r_depth;
    logic [DW-1:0]     r_want;
    logic [DW-1:0]     r_k;
    logic              r_cmd;
    logic [SIZE_W-1:0] r_size;
    logic [OFFS_W-1:0] r_offs;
    t_node             r_val;
    logic              r_stat;
    logic [BLK_W-1:0]  r_blk;
    logic              r_out_valid;
    logic              r_out_stat;
    logic [BLK_W-1:0]  r_out_blk;

    t_node             rd_node;
    t_node             par_val;
    logic [CW-1:0]     total;
    logic [CW-1:0]     blk_bytes;
    logic [AW-1:0]     sib;
    logic [AW-1:0]     par;
    logic [AW-1:0]     left;
    logic [AW-1:0]     leaf;
    logic [AW-1:0]     pos;
    logic [OW-1:0]     offs_w;
    logic [IW-1:0]     bidx;
    logic [AW-1:0]     down;
    logic [5:0]        rng_sh;

    assign rd_node   = t_node'(i_mem_rdata);
    assign total     = CW'(PAGE_BYTES) << i_order;
    assign blk_bytes = CW'(PAGE_BYTES) << r_k;
    assign sib       = r_i[0] ? r_i + 1'b1 : r_i - 1'b1;
    assign par       = (r_i - 1'b1) >> 1;
    assign left      = {r_i[AW-2:0], 1'b1};
    assign leaf      = ((r_i + 1'b1) << (r_want - r_depth)) - 1'b1;
    assign pos       = r_i - ((AW'(1) << r_want) - 1'b1);
    assign offs_w    = OW'(pos << r_k) << PS;
    assign bidx      = IW'(PS) + IW'(i_order) - IW'(r_depth) - 1'b1;
    assign down      = left + AW'(r_offs[bidx]);
    assign rng_sh    = 6'(PS) + 6'(i_order);

    always_comb begin
        if (r_val == NS_FREE && rd_node == NS_FREE) begin
            par_val = NS_FREE;
        end else if (r_val == NS_USED && rd_node == NS_USED) begin
            par_val = NS_USED;
        end else begin
            par_val = NS_PART;
        end
    end

    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_i;
        o_mem_wdata = NS_FREE;
        o_mem_raddr = r_i;
        case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr;
            end
            S_MARK: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = r_val;
            end
            S_UP_RD: o_mem_raddr = sib;
            S_UP_EV: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = par;
                o_mem_wdata = par_val;
            end
            S_FR_EV: o_mem_raddr = left;
            default: ;
        endcase
    end

    assign i_req.ready        = (r_state == S_IDLE) && !i_clear;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_stat;
    assign o_rsp.block_offset = r_out_blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready && !(r_state == S_DONE && !i_clear)) begin
                r_out_valid <= 1'b0;
            end
            if (i_clear) begin
                r_state <= S_CLEAR;
                r_clr   <= '0;
            end else begin
                case (r_state)
                    S_CLEAR: begin
                        r_clr <= r_clr + 1'b1;
                        if (r_clr == AW'(NODES - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (i_req.valid) begin
                            r_cmd   <= i_req.command;
                            r_size  <= i_req.size_bytes;
                            r_offs  <= i_req.free_offset;
                            r_i     <= '0;
                            r_depth <= '0;
                            r_k     <= '0;
                            r_stat  <= STAT_ERR;
                            r_blk   <= '0;
                            if (i_req.command == CMD_ALLOC) begin
                                if (i_req.size_bytes == '0 ||
                                    CW'(i_req.size_bytes) > total) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_ROUND;
                                end
                            end else if ((i_req.free_offset >> rng_sh) != '0) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_FR_RD;
                            end
                        end
                    end
                    S_ROUND: begin
                        if (r_k < i_order && blk_bytes < CW'(r_size)) begin
                            r_k <= r_k + 1'b1;
                        end else begin
                            r_want  <= i_order - r_k;
                            r_state <= S_SK_RD;
                        end
                    end
                    S_SK_RD: r_state <= S_SK_EV;
                    S_SK_EV: begin
                        if (rd_node == NS_USED ||
                            (r_depth == r_want && rd_node == NS_PART)) begin
                            r_state <= S_SK_UP;
                        end else if (rd_node == NS_FREE) begin
                            r_i     <= leaf;
                            r_depth <= r_want;
                            r_val   <= NS_USED;
                            r_state <= S_MARK;
                        end else begin
                            r_i     <= left;
                            r_depth <= r_depth + 1'b1;
                            r_state <= S_SK_RD;
                        end
                    end
                    S_SK_UP: begin
                        if (r_i == '0) begin
                            r_state <= S_DONE;
                        end else if (r_i[0]) begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_SK_RD;
                        end else begin
                            r_i     <= par;
                            r_depth <= r_depth - 1'b1;
                        end
                    end
                    S_FR_RD: r_state <= S_FR_EV;
                    S_FR_EV: begin
                        if (rd_node == NS_FREE) begin
                            r_state <= S_DONE;
                        end else if (rd_node == NS_USED) begin
                            if (r_depth == i_order) begin
                                r_val   <= NS_FREE;
                                r_state <= S_MARK;
                            end else begin
                                r_state <= S_FR_CH;
                            end
                        end else if (r_depth >= i_order) begin
                            r_state <= S_DONE;
                        end else begin
                            r_i     <= down;
                            r_depth <= r_depth + 1'b1;
                            r_state <= S_FR_RD;
                        end
                    end
                    S_FR_CH: begin
                        if (rd_node == NS_FREE) begin
                            r_val   <= NS_FREE;
                            r_state <= S_MARK;
                        end else begin
                            r_i     <= down;
                            r_depth <= r_depth + 1'b1;
                            r_state <= S_FR_RD;
                        end
                    end
                    S_MARK: begin
                        r_stat <= STAT_OK;
                        if (r_cmd == CMD_ALLOC) begin
                            r_blk <= offs_w[BLK_W-1:0];
                        end
                        r_state <= (r_i == '0) ? S_DONE : S_UP_RD;
                    end
                    S_UP_RD: r_state <= S_UP_EV;
                    S_UP_EV: begin
                        r_i     <= par;
                        r_val   <= par_val;
                        r_state <= (par == '0) ? S_DONE : S_UP_RD;
                    end
                    S_DONE: begin
                        if (!r_out_valid || o_rsp.ready) begin
                            r_out_valid <= 1'b1;
                            r_out_stat  <= r_stat;
                            r_out_blk   <= r_blk;
                            r_state     <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end
endmodule

// File: design/buddy_page_allocator_core.sv
// Buddy page allocator core: order register, node-state memory and sequencer.
// Allocate and free requests run one at a time against a node-state RAM with one write and
// one registered read port. An allocate first rounds the size up to a block order, then
// walks the tree depth first, reading each node visited and stepping back up where needed,
// then repairs the ancestors of the marked node; a free walks down the tree level by level
// and then repairs the ancestors back up. After reset and after each write of the order
// register the RAM is cleared, one node per cycle, all 2^(MAX_ORDER+1)-1 nodes (2047 by
// default), with no request taken meanwhile.
module buddy_page_allocator_core
    import bpa_pkg::*;
#(
    parameter int MAX_ORDER  = MAX_ORDER_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [ORDER_W-1:0] i_cfg_wdata,
    bpa_req_if.sink            i_req,
    bpa_rsp_if.source          o_rsp
);
    localparam int AW    = MAX_ORDER + 1;
    localparam int DW    = $clog2(MAX_ORDER + 2);
    localparam int NODES = (1 << AW) - 1;

    logic [ORDER_W-1:0] r_order;
    logic               r_clear;
    logic [DW-1:0]      order_eff;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [1:0]         mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [1:0]         mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
            r_clear <= 1'b0;
        end else begin
            r_clear <= i_cfg_we;
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
            end
        end
    end

    assign order_eff = (32'(r_order) > MAX_ORDER) ? DW'(MAX_ORDER) : DW'(r_order);

    bpa_ram #(
        .WIDTH (2),
        .DEPTH (NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bpa_ctrl #(
        .MAX_ORDER  (MAX_ORDER),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (r_clear),
        .i_order     (order_eff),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    a_no_bad_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> mem_wdata != 2'b11)
        else $error("invalid node code written");

    a_err_zero_offs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == STAT_ERR) |-> o_rsp.block_offset == '0)
        else $error("error response with non-zero offset");

    a_cfg_blocks_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> ##1 !i_req.ready)
        else $error("request taken during tree clear");
endmodule
